// File: rtl/hsgr_pkg.sv
`timescale 1ns / 1ps

package hsgr_pkg;

  localparam int COMM_WORDS = 8;
  localparam int COMM_DEPTH = 8;
  localparam int IDX_W = $clog2(COMM_DEPTH);

  localparam logic [23:0] WIN_CTRL   = 24'ha12000;
  localparam logic [23:0] WIN_MEM    = 24'ha12002;
  localparam logic [23:0] WIN_BOOT   = 24'ha12006;
  localparam logic [23:0] WIN_WATCH  = 24'ha1200c;
  localparam logic [23:0] WIN_FLAGS  = 24'ha1200e;
  localparam logic [23:0] WIN_CMD_LO = 24'ha12010;
  localparam logic [23:0] WIN_CMD_HI = 24'ha1201f;
  localparam logic [23:0] WIN_STA_LO = 24'ha12020;
  localparam logic [23:0] WIN_STA_HI = 24'ha1202f;

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_STATUS = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_NONE,
    REG_CTRL,
    REG_MEM,
    REG_BOOT,
    REG_WATCH,
    REG_FLAGS,
    REG_CMD,
    REG_STA
  } reg_sel_t;

  typedef struct packed {
    func_t       func;
    logic        upper_lane;
    logic        lower_lane;
    logic [23:0] bus_address;
    logic [15:0] bus_data;
    logic [7:0]  sub_flag;
    logic [11:0] stopwatch_value;
    logic        wram_mode;
    logic        wram_select;
    logic        irq_enable;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        sub_reset;
    logic        sub_halt;
    logic        sub_irq_pending;
    logic        wram_switch_flag;
    logic [1:0]  pram_bank;
    logic [7:0]  pram_protect_mask;
    logic [7:0]  host_flag;
  } result_t;

endpackage

// File: rtl/hsgr_item_if.sv
`timescale 1ns / 1ps

interface hsgr_item_if;
  import hsgr_pkg::*;

  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/hsgr_result_if.sv
`timescale 1ns / 1ps

interface hsgr_result_if;
  import hsgr_pkg::*;

  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/hsgr_ram.sv
`timescale 1ns / 1ps

module hsgr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/host_side_subsystem_gate_registers.sv
`timescale 1ns / 1ps
// path: an accepted transfer passes the stage register s1, then the output register
// throughput: one transfer per cycle while results are taken, set by the single
// read-modify-write pass over the command and status RAMs (read at accept, write back when s1 fires)
// reset: synchronous, clears the control bits (halt comes up set) and the entry valid flags;
// entries never written read as zero, so no clearing pass is needed

module host_side_subsystem_gate_registers (
  input  logic          clk,
  input  logic          rst,
  hsgr_item_if.sink     item,
  hsgr_result_if.source result
);
  import hsgr_pkg::*;

  typedef struct packed {
    func_t       func;
    logic        up;
    logic        lo;
    reg_sel_t    sel;
    logic [IDX_W-1:0] idx;
    logic        in_range;
    logic [15:0] data;
    logic [7:0]  sub_flag;
    logic [11:0] stopwatch;
    logic        wram_mode;
    logic        wram_select;
    logic        irq_enable;
    logic        cmd_valid;
    logic        cmd_fwd;
    logic [15:0] cmd_fwd_data;
    logic        sta_valid;
    logic        sta_fwd;
    logic [15:0] sta_fwd_data;
  } stage_t;

  logic   s1_valid;
  stage_t s1;
  stage_t s1_next;
  logic   s1_fire;
  logic   accept;

  logic run_bit, request_bit, halt_bit, switch_flag, pending_bit;
  logic [1:0]  bank_reg;
  logic [7:0]  protect_reg, host_flag_reg;
  logic [15:0] boot_vector_word;
  logic run_next, request_next, halt_next, switch_next, pending_next;
  logic [1:0]  bank_next;
  logic [7:0]  protect_next, host_flag_next;
  logic [15:0] boot_next;
  logic        pulse;
  logic [15:0] rd;

  logic [COMM_DEPTH-1:0] cmd_valid, sta_valid;
  logic [IDX_W-1:0] rd_idx;
  logic             cmd_we, sta_we;
  logic [15:0]      cmd_wdata, cmd_rdata, sta_rdata, cmd_word, sta_word;

  logic [23:0] addr;
  logic [23:0] raw;

  logic    o_valid;
  result_t o_data;

  assign s1_fire = s1_valid && (!o_valid || result.ready);
  assign item.ready = !s1_valid || s1_fire;
  assign accept = item.valid && item.ready;

  // decode of the incoming transfer
  assign raw = item.payload.bus_address;
  assign addr = {raw[23:8], 2'b00, raw[5:0]};
  assign rd_idx = addr[IDX_W:1];

  always_comb begin
    s1_next = '0;
    s1_next.func = item.payload.func;
    s1_next.up = item.payload.upper_lane;
    s1_next.lo = item.payload.lower_lane;
    s1_next.data = item.payload.bus_data;
    s1_next.sub_flag = item.payload.sub_flag;
    s1_next.stopwatch = item.payload.stopwatch_value;
    s1_next.wram_mode = item.payload.wram_mode;
    s1_next.wram_select = item.payload.wram_select;
    s1_next.irq_enable = item.payload.irq_enable;
    if (addr == WIN_CTRL) begin
      s1_next.sel = REG_CTRL;
    end else if (addr == WIN_MEM) begin
      s1_next.sel = REG_MEM;
    end else if (addr == WIN_BOOT) begin
      s1_next.sel = REG_BOOT;
    end else if (addr == WIN_WATCH) begin
      s1_next.sel = REG_WATCH;
    end else if (addr == WIN_FLAGS) begin
      s1_next.sel = REG_FLAGS;
    end else if (addr >= WIN_CMD_LO && addr <= WIN_CMD_HI) begin
      s1_next.sel = REG_CMD;
    end else if (addr >= WIN_STA_LO && addr <= WIN_STA_HI) begin
      s1_next.sel = REG_STA;
    end else begin
      s1_next.sel = REG_NONE;
    end
    if (item.payload.func == FUNC_STATUS) begin
      s1_next.idx = raw[IDX_W-1:0];
      s1_next.in_range = (raw[23:IDX_W] == '0) &&
                         ({1'b0, raw[IDX_W-1:0]} < (IDX_W+1)'(COMM_WORDS));
    end else begin
      s1_next.idx = rd_idx;
      s1_next.in_range = {1'b0, rd_idx} < (IDX_W+1)'(COMM_WORDS);
    end
    // forwarding from the write-back in flight
    s1_next.cmd_valid = cmd_valid[rd_idx];
    s1_next.cmd_fwd = cmd_we && (s1.idx == rd_idx);
    s1_next.cmd_fwd_data = cmd_wdata;
    s1_next.sta_valid = sta_valid[rd_idx];
    s1_next.sta_fwd = sta_we && (s1.idx == rd_idx);
    s1_next.sta_fwd_data = s1.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  hsgr_ram #(.WIDTH(16), .DEPTH(COMM_DEPTH)) u_cmd_ram (
    .clk   (clk),
    .we    (cmd_we),
    .waddr (s1.idx),
    .wdata (cmd_wdata),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (cmd_rdata)
  );

  hsgr_ram #(.WIDTH(16), .DEPTH(COMM_DEPTH)) u_sta_ram (
    .clk   (clk),
    .we    (sta_we),
    .waddr (s1.idx),
    .wdata (s1.data),
    .re    (accept),
    .raddr (rd_idx),
    .rdata (sta_rdata)
  );

  always_comb begin
    cmd_word = s1.cmd_fwd ? s1.cmd_fwd_data : (s1.cmd_valid ? cmd_rdata : 16'h0000);
    sta_word = s1.sta_fwd ? s1.sta_fwd_data : (s1.sta_valid ? sta_rdata : 16'h0000);
  end

  // read-modify-write of the registers
  always_comb begin
    run_next = run_bit;
    request_next = request_bit;
    halt_next = halt_bit;
    switch_next = switch_flag;
    pending_next = pending_bit;
    bank_next = bank_reg;
    protect_next = protect_reg;
    host_flag_next = host_flag_reg;
    boot_next = boot_vector_word;
    pulse = 1'b0;
    rd = 16'h0000;
    cmd_we = 1'b0;
    cmd_wdata = cmd_word;
    sta_we = 1'b0;
    case (s1.func)
      FUNC_READ: begin
        case (s1.sel)
          REG_CTRL: rd = {s1.irq_enable, 6'b0, pending_bit, 6'b0, request_bit, run_bit};
          REG_MEM: rd = {protect_reg, bank_reg, 3'b0, s1.wram_mode, switch_flag,
                         s1.wram_mode ? s1.wram_select : !switch_flag};
          REG_BOOT: rd = boot_vector_word;
          REG_WATCH: rd = {4'h0, s1.stopwatch};
          REG_FLAGS: rd = {host_flag_reg, s1.sub_flag};
          REG_CMD: rd = s1.in_range ? cmd_word : 16'h0000;
          REG_STA: rd = s1.in_range ? sta_word : 16'h0000;
          default: rd = s1.data;
        endcase
      end
      FUNC_WRITE: begin
        case (s1.sel)
          REG_CTRL: begin
            if (s1.lo) begin
              pulse = run_bit && !s1.data[0];
              run_next = s1.data[0];
              request_next = s1.data[1];
              halt_next = !s1.data[0] || s1.data[1];
            end
            if (s1.up && s1.data[8] && s1.irq_enable) begin
              pending_next = 1'b1;
            end
          end
          REG_MEM: begin
            if (s1.lo) begin
              if (s1.data[1]) begin
                switch_next = 1'b1;
              end
              bank_next = s1.data[7:6];
            end
            if (s1.up) begin
              protect_next = s1.data[15:8];
            end
          end
          REG_BOOT: boot_next = s1.data;
          REG_FLAGS: begin
            if (s1.up) begin
              host_flag_next = s1.data[15:8];
            end
          end
          REG_CMD: begin
            cmd_we = s1_fire && s1.in_range;
            if (s1.lo) begin
              cmd_wdata[7:0] = s1.data[7:0];
            end
            if (s1.up) begin
              cmd_wdata[15:8] = s1.data[15:8];
            end
          end
          default: ;
        endcase
      end
      FUNC_STATUS: sta_we = s1_fire && s1.in_range;
      default: begin
        if (s1.data[0]) begin
          pending_next = 1'b0;
        end
        if (s1.data[1]) begin
          switch_next = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_bit <= 1'b0;
      request_bit <= 1'b0;
      halt_bit <= 1'b1;
      switch_flag <= 1'b0;
      pending_bit <= 1'b0;
      bank_reg <= 2'b00;
      protect_reg <= 8'h00;
      host_flag_reg <= 8'h00;
      boot_vector_word <= 16'h0000;
      cmd_valid <= '0;
      sta_valid <= '0;
    end else if (s1_fire) begin
      run_bit <= run_next;
      request_bit <= request_next;
      halt_bit <= halt_next;
      switch_flag <= switch_next;
      pending_bit <= pending_next;
      bank_reg <= bank_next;
      protect_reg <= protect_next;
      host_flag_reg <= host_flag_next;
      boot_vector_word <= boot_next;
      if (cmd_we) begin
        cmd_valid[s1.idx] <= 1'b1;
      end
      if (sta_we) begin
        sta_valid[s1.idx] <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_fire) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      o_data.read_data <= rd;
      o_data.sub_reset <= pulse;
      o_data.sub_halt <= halt_next;
      o_data.sub_irq_pending <= pending_next;
      o_data.wram_switch_flag <= switch_next;
      o_data.pram_bank <= bank_next;
      o_data.pram_protect_mask <= protect_next;
      o_data.host_flag <= host_flag_next;
    end
  end

  assign result.valid = o_valid;
  assign result.payload = o_data;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import hsgr_pkg::*;

  localparam int DIRECTED_ROWS = 26;
  localparam int RANDOM_ACCESSES = 800;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    item_t       acc;
    bit          known;
    logic [15:0] rd;
  } plan_row_t;

  typedef struct {
    bit          known;
    logic [15:0] rd;
  } read_hint_t;

  logic clk;
  logic rst;

  hsgr_item_if   item_ch ();
  hsgr_result_if result_ch ();

  host_side_subsystem_gate_registers DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // mirror of the register window
  logic        run_q = 1'b0;
  logic        req_q = 1'b0;
  logic        halt_q = 1'b1;
  logic        switch_q = 1'b0;
  logic [1:0]  bank_q = '0;
  logic [7:0]  protect_q = '0;
  logic        pend_q = 1'b0;
  logic [7:0]  hflag_q = '0;
  logic [15:0] boot_q = '0;
  logic [15:0] cmd_words [COMM_DEPTH] = '{default: '0};
  logic [15:0] sta_words [COMM_DEPTH] = '{default: '0};

  result_t    awaited_responses [$];
  read_hint_t read_hints [$];
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  bit         steady_flow = 1'b0;
  bit         squeeze_now = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic result_t apply_window_access(item_t acc);
    result_t     resp;
    logic [23:0] a;
    logic [23:0] idx;
    logic [15:0] d;
    resp = '0;
    a = acc.bus_address & ~24'h0000c0;
    d = acc.bus_data;
    case (acc.func)
      FUNC_READ: begin
        if (a == WIN_CTRL) begin
          resp.read_data = {acc.irq_enable, 6'd0, pend_q, 6'd0, req_q, run_q};
        end else if (a == WIN_MEM) begin
          resp.read_data = {protect_q, bank_q, 3'd0, acc.wram_mode, switch_q,
                            acc.wram_mode ? acc.wram_select : !switch_q};
        end else if (a == WIN_BOOT) begin
          resp.read_data = boot_q;
        end else if (a == WIN_WATCH) begin
          resp.read_data = {4'd0, acc.stopwatch_value};
        end else if (a == WIN_FLAGS) begin
          resp.read_data = {hflag_q, acc.sub_flag};
        end else if (a >= WIN_CMD_LO && a <= WIN_CMD_HI) begin
          idx = (a - WIN_CMD_LO) >> 1;
          resp.read_data = (idx < COMM_WORDS) ? cmd_words[idx[IDX_W-1:0]] : '0;
        end else if (a >= WIN_STA_LO && a <= WIN_STA_HI) begin
          idx = (a - WIN_STA_LO) >> 1;
          resp.read_data = (idx < COMM_WORDS) ? sta_words[idx[IDX_W-1:0]] : '0;
        end else begin
          resp.read_data = d;
        end
      end
      FUNC_WRITE: begin
        if (a == WIN_CTRL) begin
          if (acc.lower_lane) begin
            if (run_q && !d[0]) resp.sub_reset = 1'b1;
            run_q = d[0];
            req_q = d[1];
            halt_q = !run_q || req_q;
          end
          if (acc.upper_lane && d[8] && acc.irq_enable) pend_q = 1'b1;
        end else if (a == WIN_MEM) begin
          if (acc.lower_lane) begin
            if (d[1]) switch_q = 1'b1;
            bank_q = d[7:6];
          end
          if (acc.upper_lane) protect_q = d[15:8];
        end else if (a == WIN_BOOT) begin
          boot_q = d;
        end else if (a == WIN_FLAGS) begin
          if (acc.upper_lane) hflag_q = d[15:8];
        end else if (a >= WIN_CMD_LO && a <= WIN_CMD_HI) begin
          idx = (a - WIN_CMD_LO) >> 1;
          if (idx < COMM_WORDS) begin
            if (acc.lower_lane) cmd_words[idx[IDX_W-1:0]][7:0] = d[7:0];
            if (acc.upper_lane) cmd_words[idx[IDX_W-1:0]][15:8] = d[15:8];
          end
        end
      end
      FUNC_STATUS: begin
        if (acc.bus_address < COMM_WORDS) sta_words[acc.bus_address[IDX_W-1:0]] = d;
      end
      default: begin
        if (d[0]) pend_q = 1'b0;
        if (d[1]) switch_q = 1'b0;
      end
    endcase
    resp.sub_halt = halt_q;
    resp.sub_irq_pending = pend_q;
    resp.wram_switch_flag = switch_q;
    resp.pram_bank = bank_q;
    resp.pram_protect_mask = protect_q;
    resp.host_flag = hflag_q;
    return resp;
  endfunction

  function automatic plan_row_t row(func_t f, bit up, bit lo, logic [23:0] addr,
                                    logic [15:0] data, logic [7:0] sf, logic [11:0] sw,
                                    bit mode, bit sel, bit en, bit known, logic [15:0] rd);
    plan_row_t r;
    r.acc.func = f;
    r.acc.upper_lane = up;
    r.acc.lower_lane = lo;
    r.acc.bus_address = addr;
    r.acc.bus_data = data;
    r.acc.sub_flag = sf;
    r.acc.stopwatch_value = sw;
    r.acc.wram_mode = mode;
    r.acc.wram_select = sel;
    r.acc.irq_enable = en;
    r.known = known;
    r.rd = rd;
    return r;
  endfunction

  function automatic item_t random_access();
    item_t       acc;
    int unsigned pick;
    logic [5:0]  offs;
    pick = $urandom_range(0, 9);
    acc.func = (pick < 4) ? FUNC_READ : (pick < 8) ? FUNC_WRITE :
               (pick == 8) ? FUNC_STATUS : FUNC_CLEAR;
    acc.upper_lane = 1'($urandom_range(0, 1));
    acc.lower_lane = 1'($urandom_range(0, 1));
    acc.bus_data = 16'($urandom);
    acc.sub_flag = 8'($urandom);
    acc.stopwatch_value = 12'($urandom);
    acc.wram_mode = 1'($urandom_range(0, 1));
    acc.wram_select = 1'($urandom_range(0, 1));
    acc.irq_enable = 1'($urandom_range(0, 1));
    case (acc.func)
      FUNC_STATUS: begin
        pick = $urandom_range(0, 9);
        acc.bus_address = (pick < 7) ? 24'($urandom_range(0, 7)) :
                          (pick < 9) ? 24'($urandom_range(8, 15)) : 24'($urandom);
      end
      FUNC_CLEAR: begin
        acc.bus_address = 24'($urandom);
      end
      default: begin
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          acc.bus_address = 24'($urandom);
        end else if (pick == 1) begin
          acc.bus_address = WIN_CTRL ^ (24'd1 << $urandom_range(0, 23));
        end else begin
          case ($urandom_range(0, 7))
            0: offs = WIN_CTRL[5:0];
            1: offs = WIN_MEM[5:0];
            2: offs = WIN_BOOT[5:0];
            3: offs = WIN_WATCH[5:0];
            4: offs = WIN_FLAGS[5:0];
            5: offs = WIN_CMD_LO[5:0] + 6'($urandom_range(0, 15));
            6: offs = WIN_STA_LO[5:0] + 6'($urandom_range(0, 15));
            default: offs = 6'($urandom_range(0, 63));
          endcase
          acc.bus_address = {WIN_CTRL[23:8], 2'($urandom_range(0, 3)), offs};
        end
      end
    endcase
    return acc;
  endfunction

  task automatic offer(input item_t acc, input bit known, input logic [15:0] rd);
    int unsigned gap;
    read_hint_t  hint;
    hint.known = known;
    hint.rd = rd;
    read_hints.push_back(hint);
    gap = steady_flow ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.payload <= acc;
    @(posedge clk);
    while (!(item_ch.valid && item_ch.ready)) @(posedge clk);
  endtask

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    result_t    want;
    result_t    got;
    read_hint_t hint;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.payload;
        if (awaited_responses.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, got %h", $time, got);
          mismatch_count++;
        end else begin
          want = awaited_responses.pop_front();
          compare_field("read_data", want.read_data, got.read_data);
          compare_field("sub_reset", 16'(want.sub_reset), 16'(got.sub_reset));
          compare_field("sub_halt", 16'(want.sub_halt), 16'(got.sub_halt));
          compare_field("sub_irq_pending", 16'(want.sub_irq_pending),
                        16'(got.sub_irq_pending));
          compare_field("wram_switch_flag", 16'(want.wram_switch_flag),
                        16'(got.wram_switch_flag));
          compare_field("pram_bank", 16'(want.pram_bank), 16'(got.pram_bank));
          compare_field("pram_protect_mask", 16'(want.pram_protect_mask),
                        16'(got.pram_protect_mask));
          compare_field("host_flag", 16'(want.host_flag), 16'(got.host_flag));
        end
      end
      if (item_ch.valid && item_ch.ready) begin
        want = apply_window_access(item_ch.payload);
        hint = read_hints.pop_front();
        if (hint.known) want.read_data = hint.rd;
        awaited_responses.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("host_side_subsystem_gate_registers regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: per-transfer stall, one long hold-off on request
  initial begin : receiver
    int unsigned hold;
    result_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (squeeze_now) begin
        hold = SQUEEZE_CYCLES;
        squeeze_now = 1'b0;
      end else begin
        hold = steady_flow ? 0 : $urandom_range(0, 11);
      end
      @(negedge clk);
      if (hold != 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(result_ch.valid && result_ch.ready)) @(posedge clk);
    end
  end

  initial begin : stimulus
    plan_row_t plan [DIRECTED_ROWS];
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.payload = '0;
    plan = '{
      row(FUNC_READ,   0, 0, WIN_CTRL,     16'h0000, 8'h00, 12'h000, 0, 0, 0, 1, 16'h0000),
      row(FUNC_READ,   0, 0, WIN_MEM,      16'h0000, 8'h00, 12'h000, 0, 0, 0, 1, 16'h0001),
      row(FUNC_READ,   1, 1, WIN_WATCH,    16'h0000, 8'hff, 12'hfff, 1, 1, 1, 1, 16'h0fff),
      row(FUNC_READ,   0, 0, WIN_FLAGS,    16'hffff, 8'hff, 12'h000, 0, 0, 0, 1, 16'h00ff),
      row(FUNC_READ,   0, 0, 24'hffffff,   16'ha5a5, 8'h00, 12'h000, 0, 0, 0, 1, 16'ha5a5),
      row(FUNC_READ,   0, 0, WIN_STA_HI,   16'h1234, 8'h00, 12'h000, 0, 0, 0, 1, 16'h0000),
      row(FUNC_READ,   0, 0, WIN_CTRL,     16'h0000, 8'h00, 12'h000, 0, 0, 1, 1, 16'h8000),
      row(FUNC_WRITE,  0, 1, WIN_CTRL,     16'h0001, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_WRITE,  1, 1, WIN_CTRL,     16'h0100, 8'h00, 12'h000, 0, 0, 1, 0, 16'h0000),
      row(FUNC_READ,   0, 0, WIN_CTRL,     16'h0000, 8'h00, 12'h000, 0, 0, 1, 0, 16'h0000),
      row(FUNC_CLEAR,  0, 0, 24'h000000,   16'h0001, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_WRITE,  1, 1, WIN_MEM,      16'hffc2, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_READ,   0, 0, 24'ha120c2,   16'h0000, 8'h00, 12'h000, 1, 0, 0, 0, 16'h0000),
      row(FUNC_CLEAR,  0, 0, 24'h000000,   16'hfffe, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_WRITE,  0, 0, WIN_BOOT,     16'hffff, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_READ,   0, 0, 24'ha12046,   16'h0000, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_WRITE,  1, 0, WIN_FLAGS,    16'hff00, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_WRITE,  0, 1, WIN_CMD_HI,   16'hffff, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_WRITE,  1, 0, WIN_CMD_LO,   16'h1234, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_READ,   0, 0, 24'ha1201e,   16'h0000, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_STATUS, 0, 0, 24'h000007,   16'hffff, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_STATUS, 0, 0, 24'h000008,   16'h5555, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_READ,   0, 0, 24'ha120ef,   16'h0000, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_WRITE,  1, 1, WIN_STA_LO,   16'hffff, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_READ,   0, 0, WIN_STA_LO,   16'h0000, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000),
      row(FUNC_WRITE,  0, 1, WIN_CTRL,     16'h0003, 8'h00, 12'h000, 0, 0, 0, 0, 16'h0000)
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int k = 0; k < DIRECTED_ROWS; k++) offer(plan[k].acc, plan[k].known, plan[k].rd);
    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      steady_flow = (n >= 150 && n < 250) || (n >= 600 && n < 680);
      if (n == 400) squeeze_now = 1'b1;
      offer(random_access(), 1'b0, 16'h0000);
    end
    @(negedge clk);
    item_ch.valid <= 1'b0;
    steady_flow = 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (awaited_responses.size() != 0) begin
      $display("%0t: %0d transfers still expected, got none", $time,
               awaited_responses.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("host_side_subsystem_gate_registers regression: pass");
    end else begin
      $display("host_side_subsystem_gate_registers regression: fail");
    end
    $finish;
  end

endmodule
